>>> rtl/csvt_pkg.sv
// Package for the CSV field tokenizer: item structs, config struct,
// register map, line phase codes and reset constants.
// No dependencies.
package csvt_pkg;

  // Field limit default and output index width
  localparam int MaxFieldsDef = 64;
  localparam int IdxW         = 6;
  localparam int IdxMax       = 63;

  // Config port geometry
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  // Fixed characters
  localparam logic [7:0] ChrLf    = 8'd10;
  localparam logic [7:0] ChrCr    = 8'd13;
  localparam logic [7:0] ChrSpace = 8'd32;
  localparam logic [7:0] ChrTab   = 8'd9;

  // Register reset values
  localparam logic [7:0] SepRst     = 8'd59;  // ';'
  localparam logic [7:0] QuoteRst   = 8'd34;  // '"'
  localparam logic [7:0] CommentRst = 8'd35;  // '#'
  localparam logic       SkipHdrRst = 1'b1;

  // Register index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_SEP     = 2'd0,
    REG_QUOTE   = 2'd1,
    REG_COMMENT = 2'd2,
    REG_SKIP    = 2'd3
  } reg_idx_e;

  // Where we are within the current line
  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,  // leading whitespace
    PH_REC  = 2'd1,  // inside a record
    PH_DROP = 2'd2   // dropping a comment or header line
  } line_phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      byte_out;
    logic            data_valid;
    logic            field_end;
    logic            record_end;
    logic [IdxW-1:0] field_index;
    logic            field_overflow;
  } out_item_t;

  // Config values plus the header-pending reload strobe
  typedef struct packed {
    logic [7:0] separator_char;
    logic [7:0] quote_char;
    logic [7:0] comment_char;
    logic       skip_header;
    logic       hdr_load;
    logic       hdr_value;
  } cfg_t;

endpackage

>>> rtl/csvt_regs.sv
// APB-style configuration registers of the CSV field tokenizer.
// Depends on csvt_pkg.
module csvt_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csvt_pkg::CfgAddrW-1:0] paddr,
  input  logic [csvt_pkg::CfgDataW-1:0] pwdata,
  output logic [csvt_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output csvt_pkg::cfg_t                cfg_o
);
  import csvt_pkg::*;

  logic       wr_en;
  reg_idx_e   idx;
  logic [7:0] sep_q, quote_q, comment_q;
  logic       skip_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q     <= SepRst;
      quote_q   <= QuoteRst;
      comment_q <= CommentRst;
      skip_q    <= SkipHdrRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEP:     sep_q     <= pwdata[7:0];
        REG_QUOTE:   quote_q   <= pwdata[7:0];
        REG_COMMENT: comment_q <= pwdata[7:0];
        REG_SKIP:    skip_q    <= pwdata[0];
        default:     sep_q     <= sep_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_SEP:     prdata = CfgDataW'(sep_q);
      REG_QUOTE:   prdata = CfgDataW'(quote_q);
      REG_COMMENT: prdata = CfgDataW'(comment_q);
      REG_SKIP:    prdata = CfgDataW'(skip_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.separator_char = sep_q;
  assign cfg_o.quote_char     = quote_q;
  assign cfg_o.comment_char   = comment_q;
  assign cfg_o.skip_header    = skip_q;
  // skip_header write also reloads the header-pending flag
  assign cfg_o.hdr_load       = wr_en && (idx == REG_SKIP);
  assign cfg_o.hdr_value      = pwdata[0];

endmodule

>>> rtl/csvt_core.sv
// Tokenizer state and one-byte step logic of the CSV field tokenizer.
// Depends on csvt_pkg.
module csvt_core #(
  parameter int MAX_FIELDS = csvt_pkg::MaxFieldsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,    // process item_i this cycle
  input  csvt_pkg::in_item_t   item_i,
  input  csvt_pkg::cfg_t       cfg_i,
  output logic                 res_valid_o,
  output csvt_pkg::out_item_t  res_o
);
  import csvt_pkg::*;

  localparam int FcW    = $clog2(MAX_FIELDS + 1);
  localparam int IdxCap = (MAX_FIELDS - 1 < IdxMax) ? MAX_FIELDS - 1 : IdxMax;

  line_phase_e      phase_q, phase_d;
  logic             iq_q, iq_d, qp_q, qp_d, hp_q, hp_d, afs_q, afs_d;
  logic [FcW-1:0]   fc_q, fc_d;

  // Step: next state and result item for one byte
  always_comb begin
    logic [7:0]     c;
    logic           rec, unq, afs_u, enter;
    logic           iq_b, qp_b, afs_b;
    logic [FcW-1:0] fc_b;

    c     = item_i.byte_in;
    rec   = 1'b0;
    unq   = 1'b0;
    enter = 1'b0;
    afs_u = afs_q;

    phase_d = (phase_q == PH_REC || phase_q == PH_DROP) ? phase_q : PH_LEAD;
    iq_d    = iq_q;
    qp_d    = qp_q;
    hp_d    = hp_q;
    afs_d   = afs_q;
    fc_d    = fc_q;

    res_valid_o          = 1'b0;
    res_o                = '0;

    if (c != ChrCr) begin
      if (phase_q == PH_DROP) begin
        if (c == ChrLf) phase_d = PH_LEAD;
      end else begin
        rec = (phase_q == PH_REC);
        // line start: skip blanks, drop comments and the header
        if (!rec) begin
          phase_d = PH_LEAD;
          if (c == ChrSpace || c == ChrTab || c == ChrLf) begin
            phase_d = PH_LEAD;
          end else if (c == cfg_i.comment_char) begin
            phase_d = PH_DROP;
          end else if (hp_q) begin
            hp_d    = 1'b0;
            phase_d = PH_DROP;
          end else begin
            enter   = 1'b1;
            rec     = 1'b1;
            phase_d = PH_REC;
          end
        end
      end
    end

    // State seen by the record logic (fresh line on entry)
    iq_b  = enter ? 1'b0 : iq_q;
    qp_b  = enter ? 1'b0 : qp_q;
    afs_b = enter ? 1'b1 : afs_q;
    fc_b  = enter ? '0 : fc_q;
    if (enter) begin
      iq_d  = 1'b0;
      qp_d  = 1'b0;
      afs_d = 1'b1;
      fc_d  = '0;
    end
    afs_u = afs_b;

    // Index and overflow use the count before this byte's separator
    res_o.field_index    = (fc_b > FcW'(IdxCap)) ? IdxW'(IdxCap) : IdxW'(fc_b);
    res_o.field_overflow = (fc_b >= FcW'(MAX_FIELDS));

    if (rec) begin
      if (iq_b) begin
        if (qp_b) begin
          qp_d = 1'b0;
          if (c == cfg_i.quote_char) begin
            // doubled quote: one literal quote
            res_valid_o      = 1'b1;
            res_o.data_valid = 1'b1;
            res_o.byte_out   = c;
          end else begin
            // field closed, byte handled outside quotes
            iq_d  = 1'b0;
            afs_u = 1'b0;
            unq   = 1'b1;
          end
        end else if (c == cfg_i.quote_char) begin
          qp_d = 1'b1;
        end else begin
          res_valid_o      = 1'b1;
          res_o.data_valid = 1'b1;
          res_o.byte_out   = c;
        end
      end else begin
        unq = 1'b1;
      end

      if (unq) begin
        priority if (c == cfg_i.separator_char) begin
          res_valid_o     = 1'b1;
          res_o.field_end = 1'b1;
          if (fc_b < FcW'(MAX_FIELDS)) fc_d = fc_b + FcW'(1);
          afs_d = 1'b1;
        end else if (c == ChrLf) begin
          res_valid_o      = 1'b1;
          res_o.field_end  = 1'b1;
          res_o.record_end = 1'b1;
          fc_d    = '0;
          afs_d   = 1'b1;
          phase_d = PH_LEAD;
        end else if (c == cfg_i.quote_char && afs_u) begin
          iq_d  = 1'b1;
          afs_d = 1'b0;
        end else begin
          res_valid_o      = 1'b1;
          res_o.data_valid = 1'b1;
          res_o.byte_out   = c;
          afs_d = 1'b0;
        end
      end
    end

    // End of text closes any open record and resets line state
    if (item_i.end_of_text) begin
      if (phase_d == PH_REC) begin
        res_valid_o      = 1'b1;
        res_o.field_end  = 1'b1;
        res_o.record_end = 1'b1;
      end
      iq_d    = 1'b0;
      qp_d    = 1'b0;
      phase_d = PH_LEAD;
      afs_d   = 1'b1;
      fc_d    = '0;
      hp_d    = cfg_i.skip_header;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      iq_q    <= 1'b0;
      qp_q    <= 1'b0;
      hp_q    <= SkipHdrRst;
      afs_q   <= 1'b1;
      fc_q    <= '0;
    end else if (cfg_i.hdr_load) begin
      hp_q <= cfg_i.hdr_value;
    end else if (step_i) begin
      phase_q <= phase_d;
      iq_q    <= iq_d;
      qp_q    <= qp_d;
      hp_q    <= hp_d;
      afs_q   <= afs_d;
      fc_q    <= fc_d;
    end
  end

endmodule

>>> rtl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: input register, step core,
// result register and configuration port. Depends on csvt_pkg,
// csvt_regs and csvt_core.
//
//   port   | dir | handshake            | payload
//   -------+-----+----------------------+------------------------------
//   in     | in  | in_valid_i/in_stall_o| in_item_i  (byte, end of text)
//   out    | out | out_valid_o/out_stall_i| out_item_o (byte, marks, index)
//   config | in  | psel/penable/pready  | paddr/pwdata/prdata
//
// One byte per clock sustained while out_stall_i is low. An accepted byte
// waits in the input register; its result is stepped into the result
// register and shown on out_item_o. The step logic between the input
// register and the result register sets that rate. Reset clears all line
// state and loads the register defaults. While the result register is
// stalled the input register holds one more byte, whether or not that
// byte gives a result.
module csv_field_tokenizer #(
  parameter int MAX_FIELDS = csvt_pkg::MaxFieldsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  csvt_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output csvt_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csvt_pkg::CfgAddrW-1:0] paddr,
  input  logic [csvt_pkg::CfgDataW-1:0] pwdata,
  output logic [csvt_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import csvt_pkg::*;

  localparam int IdxCap = (MAX_FIELDS - 1 < IdxMax) ? MAX_FIELDS - 1 : IdxMax;

  cfg_t       cfg;
  in_item_t   in_q;
  logic       in_valid_q, out_valid_q;
  out_item_t  out_q, res;
  logic       res_valid, out_free, step, accept;

  csvt_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Pipeline control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  csvt_core #(.MAX_FIELDS(MAX_FIELDS)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_item_i;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_rec_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.record_end) |-> out_item_o.field_end)
    else $error("record end without field end");

  a_ovf_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.field_overflow) |->
      (out_item_o.field_index == IdxW'(IdxCap)))
    else $error("overflow with unsaturated field index");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.data_valid) |-> (out_item_o.byte_out == 8'd0))
    else $error("mark item carries a nonzero byte");

endmodule
